// ===== rtl/core/sedfr_pkg.sv =====
// shared types and constants of the stx/etx/dle frame receiver
package sedfr_pkg;

   localparam int BYTE_W          = 8;
   localparam int IDX_W           = 5;
   localparam int CSR_IDX_W       = 2;
   localparam int FRAME_BYTES_DEF = 32;

   localparam logic [BYTE_W-1:0] START_CODE_RST  = 8'h02;
   localparam logic [BYTE_W-1:0] END_CODE_RST    = 8'h03;
   localparam logic [BYTE_W-1:0] ESCAPE_CODE_RST = 8'h10;
   localparam logic [BYTE_W-1:0] ESC_MASK        = 8'h7F;

   localparam logic [CSR_IDX_W-1:0] CSR_START_CODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_CODE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE_CODE = 2'd2;

   localparam logic CMD_BYTE    = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   typedef enum logic [2:0] {
      ST_WAIT,
      ST_READ,
      ST_ESC,
      ST_ALIGN,
      ST_DRAIN,
      ST_END
   } state_type;

endpackage

// ===== rtl/core/sedfr_cell.sv =====
// one byte cell of the frame shift chain
module sedfr_cell (
   input  logic                          clock,
   input  logic                          shift_en,
   input  logic [sedfr_pkg::BYTE_W-1:0]  nbr_data,
   output logic [sedfr_pkg::BYTE_W-1:0]  cell_data
);
   import sedfr_pkg::*;

   logic [BYTE_W-1:0] data_ff;
   logic [BYTE_W-1:0] data_in;

   assign data_in   = shift_en ? nbr_data : data_ff;
   assign cell_data = data_ff;

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

// ===== rtl/core/stx_etx_dle_frame_receiver_core.sv =====
// top level of the stx/etx/dle deframer with its byte cell chain
//
// channel | dir | handshake             | payload
// req     | in  | req_valid/req_ready   | req_command, req_rx_byte
// rsp     | out | rsp_valid/rsp_ready   | rsp_data, rsp_index, rsp_last, rsp_empty_frame
// csr     | in  | csr_valid/csr_ready   | csr_index, csr_data
//
// a request that does not close a frame is taken in the cycle it is offered
// an end code holds off requests while the chain shifts the frame to its head
// in ST_ALIGN, then the results are given out in ST_DRAIN
// (k bytes, or one empty result)
// after the last result the receiver takes requests again, a release reopens it
// rsp stalls only delay the drain, reset sets the control state and the codes to their reset values
module stx_etx_dle_frame_receiver_core #(
   parameter int FRAME_BYTES = sedfr_pkg::FRAME_BYTES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_command,
   input  logic [sedfr_pkg::BYTE_W-1:0]     req_rx_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [sedfr_pkg::BYTE_W-1:0]     rsp_data,
   output logic [sedfr_pkg::IDX_W-1:0]      rsp_index,
   output logic                             rsp_last,
   output logic                             rsp_empty_frame,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sedfr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sedfr_pkg::BYTE_W-1:0]     csr_data
);
   import sedfr_pkg::*;

   localparam int CNT_W = $clog2(FRAME_BYTES + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FRAME_BYTES);

   state_type state_ff, state_in;

   logic [BYTE_W-1:0] start_code_ff, start_code_in;
   logic [BYTE_W-1:0] end_code_ff, end_code_in;
   logic [BYTE_W-1:0] escape_code_ff, escape_code_in;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] skip_ff, skip_in;
   logic [CNT_W-1:0] pos_ff, pos_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_data_ff, rsp_data_in;
   logic [IDX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_empty_ff, rsp_empty_in;

   logic              req_fire;
   logic              is_byte;
   logic              is_release;
   logic              is_start;
   logic              is_end;
   logic              is_esc;
   logic              is_plain;
   logic              has_room;
   logic              rsp_free;
   logic              frame_empty;
   logic              last_hit;
   logic              store_en;
   logic              shift_en;
   logic [BYTE_W-1:0] shift_in;

   logic [BYTE_W-1:0] cell_data [FRAME_BYTES];
   logic [BYTE_W-1:0] nbr_data  [FRAME_BYTES];

   // byte chain, the head cell feeds the result register
   for (genvar i = 0; i < FRAME_BYTES; i++) begin : g_cell
      if (i == FRAME_BYTES - 1) begin : g_tail
         assign nbr_data[i] = shift_in;
      end else begin : g_mid
         assign nbr_data[i] = cell_data[i+1];
      end
      sedfr_cell u_cell (
         .clock     (clock),
         .shift_en  (shift_en),
         .nbr_data  (nbr_data[i]),
         .cell_data (cell_data[i])
      );
   end

   assign req_fire    = req_valid && req_ready;
   assign is_byte     = req_command == CMD_BYTE;
   assign is_release  = req_command == CMD_RELEASE;
   assign is_start    = req_rx_byte == start_code_ff;
   assign is_end      = !is_start && (req_rx_byte == end_code_ff);
   assign is_esc      = !is_start && !is_end && (req_rx_byte == escape_code_ff);
   assign is_plain    = !is_start && !is_end && !is_esc;
   assign has_room    = count_ff < FULL_CNT;
   assign rsp_free    = !rsp_valid_ff || rsp_ready;
   assign frame_empty = count_ff == '0;
   assign last_hit    = CNT_W'(pos_ff + 1'b1) == count_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_WAIT: begin
            if (req_fire && is_byte && is_start) state_in = ST_READ;
         end
         ST_READ: begin
            if (req_fire && is_byte) begin
               if (is_start)      state_in = ST_WAIT;
               else if (is_end)   state_in = ST_ALIGN;
               else if (is_esc)   state_in = ST_ESC;
               else if (has_room) state_in = ST_READ;
               else               state_in = ST_WAIT;
            end
         end
         ST_ESC: begin
            if (req_fire && is_byte) begin
               if (!is_plain)     state_in = ST_WAIT;
               else if (has_room) state_in = ST_READ;
               else               state_in = ST_WAIT;
            end
         end
         ST_ALIGN: begin
            if (skip_ff == '0) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (rsp_free && (frame_empty || last_hit)) state_in = ST_END;
         end
         ST_END: begin
            if (req_fire && is_release) state_in = ST_WAIT;
         end
         default: state_in = ST_WAIT;
      endcase
   end

   // outputs and datapath controls
   always_comb begin
      req_ready    = 1'b0;
      store_en     = 1'b0;
      shift_en     = 1'b0;
      shift_in     = req_rx_byte;
      count_in     = count_ff;
      skip_in      = skip_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_empty_in = rsp_empty_ff;
      case (state_ff)
         ST_WAIT: begin
            req_ready = 1'b1;
            if (req_fire && is_byte && is_start) count_in = '0;
         end
         ST_READ: begin
            req_ready = 1'b1;
            store_en  = req_fire && is_byte && is_plain && has_room;
            if (req_fire && is_byte && is_end) begin
               skip_in = CNT_W'(FULL_CNT - count_ff);
               pos_in  = '0;
            end
         end
         ST_ESC: begin
            req_ready = 1'b1;
            shift_in  = req_rx_byte & ESC_MASK;
            store_en  = req_fire && is_byte && is_plain && has_room;
         end
         ST_ALIGN: begin
            if (skip_ff != '0) begin
               shift_en = 1'b1;
               skip_in  = CNT_W'(skip_ff - 1'b1);
            end
         end
         ST_DRAIN: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = IDX_W'(pos_ff);
               rsp_last_in  = frame_empty || last_hit;
               rsp_empty_in = frame_empty;
               rsp_data_in  = frame_empty ? '0 : cell_data[0];
               if (!frame_empty) begin
                  shift_en = 1'b1;
                  pos_in   = CNT_W'(pos_ff + 1'b1);
               end
            end
         end
         ST_END: begin
            req_ready = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
      if (store_en) begin
         shift_en = 1'b1;
         count_in = CNT_W'(count_ff + 1'b1);
      end
   end

   // code registers
   always_comb begin
      start_code_in  = start_code_ff;
      end_code_in    = end_code_ff;
      escape_code_in = escape_code_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_START_CODE:  start_code_in  = csr_data;
            CSR_END_CODE:    end_code_in    = csr_data;
            CSR_ESCAPE_CODE: escape_code_in = csr_data;
            default: begin
               start_code_in = start_code_ff;
            end
         endcase
      end
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_WAIT;
         start_code_ff  <= START_CODE_RST;
         end_code_ff    <= END_CODE_RST;
         escape_code_ff <= ESCAPE_CODE_RST;
         count_ff       <= '0;
         skip_ff        <= '0;
         pos_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         start_code_ff  <= start_code_in;
         end_code_ff    <= end_code_in;
         escape_code_ff <= escape_code_in;
         count_ff       <= count_in;
         skip_ff        <= skip_in;
         pos_ff         <= pos_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;
   assign rsp_index       = rsp_index_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_empty_frame = rsp_empty_ff;

endmodule

// ===== rtl/core/sedfr_checker.sv =====
// port checker for the stx/etx/dle frame receiver and its bind
module sedfr_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [sedfr_pkg::BYTE_W-1:0]     rsp_data,
   input logic [sedfr_pkg::IDX_W-1:0]      rsp_index,
   input logic                             rsp_last,
   input logic                             rsp_empty_frame
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data) && $stable(rsp_index)
         && $stable(rsp_last) && $stable(rsp_empty_frame))
      else $error("result changed while stalled");

   // empty frame result shape
   a_empty_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_frame |-> rsp_last && rsp_data == '0 && rsp_index == '0)
      else $error("malformed empty frame result");

   // no request taken while a frame is still draining
   a_drain_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("request taken during frame drain");

   // drain continues after a non-final result
   a_drain_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("frame ended without last mark");

endmodule

bind stx_etx_dle_frame_receiver_core sedfr_checker u_sedfr_checker (.*);
